[design/assert_macros.svh]
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define NVGFE_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checks that an expression is never true outside reset.
`define NVGFE_ASSERT_NEVER(name, expr, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

[design/nvgfe_pkg.sv]
// Types, character codes and constants of the NMEA VTG/GGA field extractor.
package nvgfe_pkg;

	localparam int VALUE_W = 27;
	localparam int APB_ADDR_W = 3;
	localparam logic [VALUE_W-1:0] VALUE_MAX = 27'd99999999;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_V = 8'h56;
	localparam logic [7:0] CH_T = 8'h54;
	localparam logic [7:0] CH_G = 8'h47;
	localparam logic [7:0] CH_A = 8'h41;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_POINT = 8'h2E;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;

	// Register index taken from the word address bit of the APB port.
	localparam logic REG_SPEED_THRESHOLD = 1'b0;

	typedef enum logic [1:0] {
		KIND_SPEED = 2'd0,
		KIND_COURSE = 2'd1,
		KIND_UTC = 2'd2
	} field_kind_t;

	typedef enum logic [3:0] {
		SP_DOLLAR = 4'd0,
		SP_G = 4'd1,
		SP_ANY = 4'd2,
		SP_L3 = 4'd3,
		SP_L4 = 4'd4,
		SP_L5 = 4'd5,
		SP_SKIP1 = 4'd6,
		SP_SKIP2 = 4'd7,
		SP_SKIP3 = 4'd8,
		SP_SKIP4 = 4'd9,
		SP_OPEN = 4'd10,
		SP_FIELD = 4'd11
	} speed_phase_t;

	typedef enum logic [2:0] {
		HP_DOLLAR = 3'd0,
		HP_G = 3'd1,
		HP_ANY = 3'd2,
		HP_L3 = 3'd3,
		HP_L4 = 3'd4,
		HP_L5 = 3'd5,
		HP_OPEN = 3'd6,
		HP_FIELD = 3'd7
	} hdr_phase_t;

	typedef struct packed {
		logic clear;
		logic take;
	} cap_ctrl_t;

	// Header matching for the course and time recognizers: "$", "G", any, three letters.
	function automatic hdr_phase_t hdr_step(input hdr_phase_t ph, input logic [7:0] c,
			input logic [7:0] l3, input logic [7:0] l4, input logic [7:0] l5);
		hdr_phase_t nx;
		nx = HP_DOLLAR;
		case (ph)
			HP_DOLLAR: nx = (c == CH_DOLLAR) ? HP_G : HP_DOLLAR;
			HP_G: nx = (c == CH_G) ? HP_ANY : HP_DOLLAR;
			HP_ANY: nx = HP_L3;
			HP_L3: nx = (c == l3) ? HP_L4 : HP_DOLLAR;
			HP_L4: nx = (c == l4) ? HP_L5 : HP_DOLLAR;
			HP_L5: nx = (c == l5) ? HP_OPEN : HP_DOLLAR;
			default: nx = HP_DOLLAR;
		endcase
		return nx;
	endfunction

endpackage

[design/nvgfe_byte_if.sv]
// Valid/ready channel that carries one NMEA character per item.
interface nvgfe_byte_if;
	logic valid;
	logic ready;
	logic [7:0] nmea_byte;

	modport source(output valid, output nmea_byte, input ready);
	modport sink(input valid, input nmea_byte, output ready);
endinterface

[design/nvgfe_field_if.sv]
// Valid/ready channel that carries one extracted field per item.
interface nvgfe_field_if;
	import nvgfe_pkg::*;

	logic valid;
	logic ready;
	logic [1:0] field_kind;
	logic [VALUE_W-1:0] field_value;
	logic malformed;

	modport source(output valid, output field_kind, output field_value, output malformed,
		input ready);
	modport sink(input valid, input field_kind, input field_value, input malformed,
		output ready);
endinterface

[design/nmea_vtg_gga_field_extractor.sv]
// Top level of the NMEA VTG/GGA field extractor with its APB threshold register.
// Throughput: one character per cycle; the input stage stalls only while a result waits.
// Each character passes an input register, the recognizer and capture update, then the
// result register. Reset (arst_n low) clears all recognizers, captures, last speed and
// the speed threshold.
module nmea_vtg_gga_field_extractor #(
	parameter int FIELD_CHARS = 16
) (
	input logic clk,
	input logic arst_n,
	nvgfe_byte_if.sink nmea,
	nvgfe_field_if.source field,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [nvgfe_pkg::APB_ADDR_W-1:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import nvgfe_pkg::*;

`include "assert_macros.svh"

	logic [7:0] byte_s1;
	logic valid_s1;
	logic adv;

	logic [VALUE_W-1:0] thr_q;
	logic [VALUE_W-1:0] last_speed_q;

	speed_phase_t sp_q, sp_d;
	hdr_phase_t cp_q, cp_d;
	hdr_phase_t tp_q, tp_d;

	cap_ctrl_t sp_ctrl, cp_ctrl, tp_ctrl;
	logic [VALUE_W-1:0] cap_value [3];
	logic cap_bad [3];
	logic sp_done, cp_done, tp_done;
	logic [2:0] done;

	logic out_valid_q;
	field_kind_t out_kind_q;
	logic [VALUE_W-1:0] out_value_q;
	logic out_bad_q;

	logic [VALUE_W-1:0] res_value;
	field_kind_t res_kind;
	logic res_bad;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_SPEED_THRESHOLD) ? 32'(thr_q) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= '0;
		end else if (psel && penable && pwrite && (paddr[2] == REG_SPEED_THRESHOLD)) begin
			thr_q <= pwdata[VALUE_W-1:0];
		end
	end

	assign adv = valid_s1 && (!out_valid_q || field.ready);
	assign nmea.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (nmea.ready) begin
			valid_s1 <= nmea.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (nmea.ready && nmea.valid) begin
			byte_s1 <= nmea.nmea_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q <= SP_DOLLAR;
			cp_q <= HP_DOLLAR;
			tp_q <= HP_DOLLAR;
		end else if (adv) begin
			sp_q <= sp_d;
			cp_q <= cp_d;
			tp_q <= tp_d;
		end
	end

	assign done = {tp_done, cp_done, sp_done};

	always_comb begin
		sp_d = SP_DOLLAR;
		sp_ctrl = '0;
		sp_done = 1'b0;
		case (sp_q)
			SP_DOLLAR: sp_d = (byte_s1 == CH_DOLLAR) ? SP_G : SP_DOLLAR;
			SP_G: sp_d = (byte_s1 == CH_G) ? SP_ANY : SP_DOLLAR;
			SP_ANY: sp_d = SP_L3;
			SP_L3: sp_d = (byte_s1 == CH_V) ? SP_L4 : SP_DOLLAR;
			SP_L4: sp_d = (byte_s1 == CH_T) ? SP_L5 : SP_DOLLAR;
			SP_L5: sp_d = (byte_s1 == CH_G) ? SP_SKIP1 : SP_DOLLAR;
			SP_SKIP1: sp_d = (byte_s1 == CH_COMMA) ? SP_SKIP2 : SP_SKIP1;
			SP_SKIP2: sp_d = (byte_s1 == CH_COMMA) ? SP_SKIP3 : SP_SKIP2;
			SP_SKIP3: sp_d = (byte_s1 == CH_COMMA) ? SP_SKIP4 : SP_SKIP3;
			SP_SKIP4: sp_d = (byte_s1 == CH_COMMA) ? SP_OPEN : SP_SKIP4;
			SP_OPEN: begin
				sp_d = (byte_s1 == CH_COMMA) ? SP_FIELD : SP_OPEN;
				sp_ctrl.clear = adv && (byte_s1 == CH_COMMA);
			end
			SP_FIELD: begin
				if (byte_s1 == CH_COMMA) begin
					sp_d = SP_DOLLAR;
					sp_done = 1'b1;
				end else begin
					sp_d = SP_FIELD;
					sp_ctrl.take = adv;
				end
			end
			default: sp_d = SP_DOLLAR;
		endcase
	end

	always_comb begin
		cp_d = HP_DOLLAR;
		cp_ctrl = '0;
		cp_done = 1'b0;
		case (cp_q)
			HP_OPEN: begin
				cp_d = (byte_s1 == CH_COMMA) ? HP_FIELD : HP_OPEN;
				cp_ctrl.clear = adv && (byte_s1 == CH_COMMA);
			end
			HP_FIELD: begin
				if (byte_s1 == CH_COMMA) begin
					cp_d = HP_DOLLAR;
					cp_done = 1'b1;
				end else begin
					cp_d = HP_FIELD;
					cp_ctrl.take = adv;
				end
			end
			default: cp_d = hdr_step(cp_q, byte_s1, CH_V, CH_T, CH_G);
		endcase
	end

	always_comb begin
		tp_d = HP_DOLLAR;
		tp_ctrl = '0;
		tp_done = 1'b0;
		case (tp_q)
			HP_OPEN: begin
				tp_d = (byte_s1 == CH_COMMA) ? HP_FIELD : HP_OPEN;
				tp_ctrl.clear = adv && (byte_s1 == CH_COMMA);
			end
			HP_FIELD: begin
				if ((byte_s1 == CH_COMMA) || (byte_s1 == CH_POINT)) begin
					tp_d = HP_DOLLAR;
					tp_done = 1'b1;
				end else begin
					tp_d = HP_FIELD;
					tp_ctrl.take = adv;
				end
			end
			default: tp_d = hdr_step(tp_q, byte_s1, CH_G, CH_G, CH_A);
		endcase
	end

	nvgfe_capture #(.FIELD_CHARS(FIELD_CHARS)) u_cap_speed (
		.clk(clk), .arst_n(arst_n), .ctrl(sp_ctrl), .milli(1'b1), .char_in(byte_s1),
		.value(cap_value[0]), .bad(cap_bad[0])
	);

	nvgfe_capture #(.FIELD_CHARS(FIELD_CHARS)) u_cap_course (
		.clk(clk), .arst_n(arst_n), .ctrl(cp_ctrl), .milli(1'b1), .char_in(byte_s1),
		.value(cap_value[1]), .bad(cap_bad[1])
	);

	nvgfe_capture #(.FIELD_CHARS(FIELD_CHARS)) u_cap_time (
		.clk(clk), .arst_n(arst_n), .ctrl(tp_ctrl), .milli(1'b0), .char_in(byte_s1),
		.value(cap_value[2]), .bad(cap_bad[2])
	);

	// Speed wins over course, course over time, when fields close on the same character.
	always_comb begin
		if (done[0]) begin
			res_kind = KIND_SPEED;
			res_value = (cap_value[0] < thr_q) ? '0 : cap_value[0];
			res_bad = cap_bad[0];
		end else if (done[1]) begin
			res_kind = KIND_COURSE;
			res_value = (last_speed_q < thr_q) ? '0 : cap_value[1];
			res_bad = cap_bad[1];
		end else begin
			res_kind = KIND_UTC;
			res_value = cap_value[2];
			res_bad = cap_bad[2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_speed_q <= '0;
		end else if (adv && done[0]) begin
			last_speed_q <= cap_value[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && (done != 3'b000)) begin
			out_valid_q <= 1'b1;
		end else if (field.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && (done != 3'b000)) begin
			out_kind_q <= res_kind;
			out_value_q <= res_value;
			out_bad_q <= res_bad;
		end
	end

	assign field.valid = out_valid_q;
	assign field.field_kind = out_kind_q;
	assign field.field_value = out_value_q;
	assign field.malformed = out_bad_q;

	`NVGFE_ASSERT(a_close_gives_result, adv && (done != 3'b000) |=> out_valid_q, "no result")
	`NVGFE_ASSERT(a_last_speed, adv && done[0] |=> last_speed_q == $past(cap_value[0]), "stale speed")
	`NVGFE_ASSERT_NEVER(a_value_range, out_valid_q && (out_value_q > VALUE_MAX), "value above limit")
	`NVGFE_ASSERT(a_stall_cause, !nmea.ready |-> out_valid_q && !field.ready, "stall without result")
endmodule

[design/nvgfe_capture.sv]
// Field capture lane: accumulates digits of one field with length, point and error tracking.
module nvgfe_capture #(
	parameter int FIELD_CHARS = 16
) (
	input logic clk,
	input logic arst_n,
	input nvgfe_pkg::cap_ctrl_t ctrl,
	input logic milli,
	input logic [7:0] char_in,
	output logic [nvgfe_pkg::VALUE_W-1:0] value,
	output logic bad
);
	import nvgfe_pkg::*;

	localparam int LEN_W = $clog2(FIELD_CHARS + 1);
	localparam int SUM_W = VALUE_W + 4;

	logic [VALUE_W-1:0] value_q;
	logic [LEN_W-1:0] len_q;
	logic [2:0] frac_q;
	logic bad_q;

	logic is_digit;
	logic [3:0] digit;
	logic [6:0] scale;
	logic [SUM_W-1:0] sum;
	logic upd;
	logic full;

	always_comb begin
		is_digit = (char_in >= CH_ZERO) && (char_in <= CH_NINE);
		digit = char_in[3:0];
		case (frac_q)
			3'd1: scale = 7'd100;
			3'd2: scale = 7'd10;
			default: scale = 7'd1;
		endcase
		if (!milli) begin
			sum = SUM_W'(value_q) * SUM_W'(10) + SUM_W'(digit);
		end else if (frac_q == 3'd0) begin
			sum = SUM_W'(value_q) * SUM_W'(10) + SUM_W'(digit) * SUM_W'(1000);
		end else begin
			sum = SUM_W'(value_q) + SUM_W'(digit) * SUM_W'(scale);
		end
		upd = !milli || (frac_q < 3'd4);
		full = len_q >= LEN_W'(FIELD_CHARS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_q <= '0;
			len_q <= '0;
			frac_q <= '0;
			bad_q <= 1'b0;
		end else if (ctrl.clear) begin
			value_q <= '0;
			len_q <= '0;
			frac_q <= '0;
			bad_q <= 1'b0;
		end else if (ctrl.take) begin
			if (full) begin
				bad_q <= 1'b1;
			end else begin
				len_q <= len_q + LEN_W'(1);
				if (is_digit) begin
					if (upd) begin
						if (sum > SUM_W'(VALUE_MAX)) begin
							value_q <= VALUE_MAX;
							bad_q <= 1'b1;
						end else begin
							value_q <= sum[VALUE_W-1:0];
						end
						if (milli && (frac_q != 3'd0)) begin
							frac_q <= frac_q + 3'd1;
						end
					end
				end else if ((char_in == CH_POINT) && milli && (frac_q == 3'd0)) begin
					frac_q <= 3'd1;
				end else begin
					bad_q <= 1'b1;
				end
			end
		end
	end

	assign value = value_q;
	assign bad = bad_q;
endmodule
